/* hw/rtl/respd_pkg.sv */
// Shared types and constants for the command deframer.
`timescale 1ns / 1ps

package respd_pkg;

  // Parser phase.
  typedef enum logic [3:0] {
    PH_WAIT     = 4'd0,
    PH_COUNT    = 4'd1,
    PH_COUNT_LF = 4'd2,
    PH_DOLLAR   = 4'd3,
    PH_LEN      = 4'd4,
    PH_LEN_LF   = 4'd5,
    PH_DATA     = 4'd6,
    PH_TRAIL1   = 4'd7,
    PH_TRAIL2   = 4'd8
  } phase_e;

  // Framing characters.
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_LOW_A  = 8'h61;
  localparam logic [7:0] CH_LOW_Z  = 8'h7A;
  localparam logic [7:0] CASE_DIFF = 8'h20;

  // Configuration registers.
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 30;
  localparam int unsigned ARGS_CFG_W = 8;
  localparam int unsigned BULK_CFG_W = 30;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ARGS     = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_BULK_LEN = 8'd1;
  localparam logic [ARGS_CFG_W-1:0] MAX_ARGS_RST     = 8'hFF;
  localparam logic [BULK_CFG_W-1:0] MAX_BULK_LEN_RST = 30'h2000_0000;

  // One result beat.
  typedef struct packed {
    logic       payload_valid;
    logic [7:0] out_byte;
    logic [7:0] arg_index;
    logic       arg_done;
    logic       cmd_done;
    logic [7:0] arg_count;
    logic       frame_error;
  } res_t;

endpackage

/* hw/rtl/respd_core.sv */
// Parser state machine: consumes one byte per step and forms its result.
`timescale 1ns / 1ps

module respd_core #(
  parameter int unsigned LEN_BITS   = 30,
  parameter int unsigned COUNT_BITS = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  step_i,
  input  logic [7:0]            byte_i,
  input  logic [COUNT_BITS-1:0] cnt_lim_i,
  input  logic [LEN_BITS-1:0]   len_lim_i,
  output respd_pkg::res_t       res_o
);
  import respd_pkg::*;

  localparam int unsigned AW     = (LEN_BITS > COUNT_BITS) ? LEN_BITS : COUNT_BITS;
  localparam int unsigned PW     = AW + 4;
  localparam int unsigned CNT1_W = COUNT_BITS + 1;

  phase_e                phase_q, phase_d;
  logic [AW-1:0]         acc_q, acc_d;
  logic                  seen_q, seen_d;
  logic [COUNT_BITS-1:0] total_q, total_d;
  logic [COUNT_BITS-1:0] cur_q, cur_d;
  logic [LEN_BITS-1:0]   left_q, left_d;

  logic          is_digit;
  logic [7:0]    dig_diff;
  logic [PW-1:0] prod;
  logic [PW-1:0] lim;
  logic          over;
  logic          err;
  logic          last_arg;
  res_t          res;

  // Decimal accumulate: acc*10 + digit, checked against the active limit.
  assign is_digit = (byte_i >= CH_ZERO) && (byte_i <= CH_NINE);
  assign dig_diff = byte_i - CH_ZERO;
  assign prod     = (PW'(acc_q) << 3) + (PW'(acc_q) << 1) + PW'(dig_diff[3:0]);
  assign lim      = (phase_q == PH_LEN) ? PW'(len_lim_i) : PW'(cnt_lim_i);
  assign over     = prod > lim;
  assign last_arg = (CNT1_W'(cur_q) + CNT1_W'(1)) >= CNT1_W'(total_q);

  always_comb begin
    phase_d = phase_q;
    acc_d   = acc_q;
    seen_d  = seen_q;
    total_d = total_q;
    cur_d   = cur_q;
    left_d  = left_q;
    err     = 1'b0;
    res     = '0;

    unique case (phase_q)
      PH_WAIT: begin
        if (byte_i == CH_STAR) begin
          acc_d   = '0;
          seen_d  = 1'b0;
          phase_d = PH_COUNT;
        end else begin
          err = 1'b1;
        end
      end
      PH_COUNT, PH_LEN: begin
        if (is_digit) begin
          if (over) begin
            err = 1'b1;
          end else begin
            acc_d  = prod[AW-1:0];
            seen_d = 1'b1;
          end
        end else if (byte_i == CH_CR && seen_q) begin
          phase_d = (phase_q == PH_COUNT) ? PH_COUNT_LF : PH_LEN_LF;
        end else begin
          err = 1'b1;
        end
      end
      PH_COUNT_LF: begin
        if (byte_i != CH_LF) begin
          err = 1'b1;
        end else begin
          total_d = acc_q[COUNT_BITS-1:0];
          cur_d   = '0;
          if (acc_q[COUNT_BITS-1:0] == '0) begin
            // empty frame closes right here
            res.cmd_done = 1'b1;
            phase_d      = PH_WAIT;
          end else begin
            phase_d = PH_DOLLAR;
          end
        end
      end
      PH_DOLLAR: begin
        if (byte_i == CH_DOLLAR) begin
          acc_d   = '0;
          seen_d  = 1'b0;
          phase_d = PH_LEN;
        end else begin
          err = 1'b1;
        end
      end
      PH_LEN_LF: begin
        if (byte_i != CH_LF) begin
          err = 1'b1;
        end else begin
          left_d  = acc_q[LEN_BITS-1:0];
          phase_d = (acc_q[LEN_BITS-1:0] == '0) ? PH_TRAIL1 : PH_DATA;
        end
      end
      PH_DATA: begin
        res.payload_valid = 1'b1;
        res.arg_index     = 8'(cur_q);
        res.out_byte      = byte_i;
        if (cur_q == '0 && byte_i >= CH_LOW_A && byte_i <= CH_LOW_Z) begin
          res.out_byte = byte_i - CASE_DIFF;
        end
        left_d = left_q - LEN_BITS'(1);
        if (left_q == LEN_BITS'(1)) begin
          phase_d = PH_TRAIL1;
        end
      end
      PH_TRAIL1: begin
        phase_d = PH_TRAIL2;
      end
      PH_TRAIL2: begin
        res.arg_done  = 1'b1;
        res.arg_index = 8'(cur_q);
        if (last_arg) begin
          res.cmd_done  = 1'b1;
          res.arg_count = 8'(total_q);
          phase_d       = PH_WAIT;
        end else begin
          cur_d   = cur_q + COUNT_BITS'(1);
          phase_d = PH_DOLLAR;
        end
      end
      default: begin
        err = 1'b1;
      end
    endcase

    if (err) begin
      phase_d         = PH_WAIT;
      res             = '0;
      res.frame_error = 1'b1;
    end
  end

  assign res_o = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_WAIT;
      acc_q   <= '0;
      seen_q  <= 1'b0;
      total_q <= '0;
      cur_q   <= '0;
      left_q  <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      acc_q   <= acc_d;
      seen_q  <= seen_d;
      total_q <= total_d;
      cur_q   <= cur_d;
      left_q  <= left_d;
    end
  end

  // An error always sends the parser back to hunting for '*'.
  a_err_resync: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && res.frame_error |=> phase_q == PH_WAIT)
    else $error("parser did not resync after frame error");

  // A finished command leaves the parser waiting for the next frame.
  a_cmd_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && res.cmd_done |=> phase_q == PH_WAIT)
    else $error("parser not idle after command end");

  // Inside the argument list the current index stays below the count.
  a_arg_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_DOLLAR || phase_q == PH_LEN || phase_q == PH_LEN_LF ||
     phase_q == PH_DATA || phase_q == PH_TRAIL1 || phase_q == PH_TRAIL2)
    |-> cur_q < total_q)
    else $error("argument index beyond argument count");

  // Payload phase never runs with nothing left to take.
  a_data_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_DATA |-> left_q != '0)
    else $error("payload phase with zero bytes left");

endmodule

/* hw/rtl/resp_array_command_deframer.sv */
// Top level of the RESP array-of-bulk-strings command deframer.
`timescale 1ns / 1ps

//  channel  | direction | beat contents
//  ---------+-----------+-----------------------------------------------------
//  s_axis   | in        | tdata[7:0] data_byte
//  m_axis   | out       | tdata: out_byte, arg_index, arg_count; tuser: flags;
//           |           | tlast: cmd_done
//  cfg      | in        | cfg_index_i: 0 max_args, 1 max_bulk_len; cfg_data_i
//
//  One byte per cycle sustained while m_axis_tready stays high; m_axis_tvalid
//  rises once a beat has passed the input register and then the result
//  register after one parser step.
//  The parser state update is the loop that sets the rate.
//  A stalled m_axis holds the result register; s_axis keeps accepting while
//  the input register is free or moves on in the same cycle.
//  Reset puts the parser in the hunt for '*' and the limits at 255 and 2^29.

module resp_array_command_deframer #(
  parameter int unsigned LEN_BITS   = 30,
  parameter int unsigned COUNT_BITS = 8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // slave stream
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [7:0]                          s_axis_tdata,  // [7:0] data_byte
  // master stream
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [7:0] out_byte, [15:8] arg_index, [23:16] arg_count
  output logic [23:0]                         m_axis_tdata,
  // [0] payload_valid, [1] arg_done, [2] frame_error
  output logic [2:0]                          m_axis_tuser,
  output logic                                m_axis_tlast,  // cmd_done
  // configuration writes
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [respd_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [respd_pkg::CFG_DATA_W-1:0]    cfg_data_i
);
  import respd_pkg::*;

  // Limits are clamped to what the counters can hold when they are written.
  localparam int unsigned LW = (LEN_BITS > BULK_CFG_W) ? LEN_BITS : BULK_CFG_W;
  localparam int unsigned CW = (COUNT_BITS > ARGS_CFG_W) ? COUNT_BITS : ARGS_CFG_W;
  localparam logic [LW-1:0] LEN_CAP     = LW'({LEN_BITS{1'b1}});
  localparam logic [CW-1:0] CNT_CAP     = CW'({COUNT_BITS{1'b1}});
  localparam logic [LW-1:0] LEN_RST_EXT = LW'(MAX_BULK_LEN_RST);
  localparam logic [CW-1:0] CNT_RST_EXT = CW'(MAX_ARGS_RST);
  localparam logic [LW-1:0] LEN_RST_CL  = (LEN_RST_EXT > LEN_CAP) ? LEN_CAP : LEN_RST_EXT;
  localparam logic [CW-1:0] CNT_RST_CL  = (CNT_RST_EXT > CNT_CAP) ? CNT_CAP : CNT_RST_EXT;
  localparam logic [LEN_BITS-1:0]   LEN_LIM_RST = LEN_RST_CL[LEN_BITS-1:0];
  localparam logic [COUNT_BITS-1:0] CNT_LIM_RST = CNT_RST_CL[COUNT_BITS-1:0];

  logic [LEN_BITS-1:0]   len_lim_q, len_lim_d;
  logic [COUNT_BITS-1:0] cnt_lim_q, cnt_lim_d;
  logic [LW-1:0]         len_wr;
  logic [CW-1:0]         cnt_wr;
  logic                  cfg_we;

  logic       in_valid_q, in_valid_d;
  logic [7:0] in_byte_q;
  logic       out_valid_q, out_valid_d;
  res_t       out_q;
  res_t       res;
  logic       in_acc;
  logic       proc;

  // ---------------- configuration ----------------
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;
  assign len_wr      = LW'(cfg_data_i[BULK_CFG_W-1:0]);
  assign cnt_wr      = CW'(cfg_data_i[ARGS_CFG_W-1:0]);

  always_comb begin
    len_lim_d = len_lim_q;
    cnt_lim_d = cnt_lim_q;
    if (cfg_we) begin
      priority if (cfg_index_i == REG_MAX_ARGS) begin
        cnt_lim_d = (cnt_wr > CNT_CAP) ? CNT_CAP[COUNT_BITS-1:0] : cnt_wr[COUNT_BITS-1:0];
      end else if (cfg_index_i == REG_MAX_BULK_LEN) begin
        len_lim_d = (len_wr > LEN_CAP) ? LEN_CAP[LEN_BITS-1:0] : len_wr[LEN_BITS-1:0];
      end else begin
        // unknown index: write dropped
        len_lim_d = len_lim_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_lim_q <= LEN_LIM_RST;
      cnt_lim_q <= CNT_LIM_RST;
    end else begin
      len_lim_q <= len_lim_d;
      cnt_lim_q <= cnt_lim_d;
    end
  end

  // ---------------- pipeline control ----------------
  // proc: input register holds a byte and the result register can take it.
  assign proc          = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || proc;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_acc) begin
      in_valid_d = 1'b1;
    end else if (proc) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (proc) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      in_byte_q <= s_axis_tdata;
    end
    if (proc) begin
      out_q <= res;
    end
  end

  // ---------------- parser ----------------
  respd_core #(
    .LEN_BITS   (LEN_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (proc),
    .byte_i    (in_byte_q),
    .cnt_lim_i (cnt_lim_q),
    .len_lim_i (len_lim_q),
    .res_o     (res)
  );

  // ---------------- result beat ----------------
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_q.arg_count, out_q.arg_index, out_q.out_byte};
  assign m_axis_tuser  = {out_q.frame_error, out_q.arg_done, out_q.payload_valid};
  assign m_axis_tlast  = out_q.cmd_done;

endmodule
